// ===== rtl/core/csr_sparse_matvec_core_defines.svh =====
// Assertion macros used by the checker of the sparse matrix-vector core.
`ifndef CSR_SPARSE_MATVEC_CORE_DEFINES_SVH
`define CSR_SPARSE_MATVEC_CORE_DEFINES_SVH

// Same-cycle implication, inactive while reset is high.
`define CSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csm assertion failed");

// Next-cycle implication, inactive while reset is high.
`define CSM_ASSERT_NEXT(label, clk, ante, cons, rst) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csm assertion failed");

// Next-cycle implication that also holds across reset.
`define CSM_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("csm assertion failed");

`endif

// ===== rtl/core/csm_pkg.sv =====
// Shared types and constants of the sparse matrix-vector core.
`default_nettype none

package csm_pkg;

   localparam int VECTOR_DEPTH_DEF = 1024;

   localparam int COLUMN_W = 10;
   localparam int VALUE_W  = 32;
   localparam int SUM_W    = 64;
   localparam int ROW_W    = 16;
   localparam int TOTAL_W  = 17;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_NONZERO = 2'd1,
      KIND_EMPTY   = 2'd2
   } kind_type;

   // Control carried along the pipeline; valid with mac low means an empty row.
   typedef struct packed {
      logic valid;
      logic mac;
      logic row_end;
   } stage_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/csm_vec_store.sv =====
// Dense vector store: one write port, one registered read port.
`default_nettype none

module csm_vec_store #(
   parameter int DEPTH  = csm_pkg::VECTOR_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire                           clock,
   input  wire                           wr_en,
   input  wire  [ADDR_W-1:0]             wr_addr,
   input  wire  [csm_pkg::VALUE_W-1:0]   wr_data,
   input  wire                           rd_en,
   input  wire  [ADDR_W-1:0]             rd_addr,
   output logic [csm_pkg::VALUE_W-1:0]   rd_data
);

   logic [csm_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic [csm_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/csm_row_acc.sv =====
// Saturating row accumulator, row counter and result register.
`default_nettype none

module csm_row_acc (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 advance,
   input  wire  csm_pkg::stage_ctrl_type       ctrl,
   input  wire  [csm_pkg::SUM_W-1:0]           product,
   input  wire  [csm_pkg::TOTAL_W-1:0]         row_total,
   output logic                                rsp_valid,
   output logic [csm_pkg::ROW_W-1:0]           rsp_row_number,
   output logic [csm_pkg::SUM_W-1:0]           rsp_row_sum,
   output logic                                rsp_overflow,
   output logic                                rsp_last_row
);

   localparam logic [csm_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(csm_pkg::SUM_W-1){1'b1}}};
   localparam logic [csm_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(csm_pkg::SUM_W-1){1'b0}}};
   localparam logic [csm_pkg::TOTAL_W-1:0] ROW_LIMIT_MAX = {1'b1, {csm_pkg::ROW_W{1'b0}}};

   logic [csm_pkg::SUM_W-1:0]   acc_ff, acc_in;
   logic                        sat_ff, sat_in;
   logic [csm_pkg::ROW_W-1:0]   row_ff, row_in;
   logic                        valid_ff, valid_in;
   logic [csm_pkg::ROW_W-1:0]   row_number_ff, row_number_in;
   logic [csm_pkg::SUM_W-1:0]   row_sum_ff, row_sum_in;
   logic                        overflow_ff, overflow_in;
   logic                        last_row_ff, last_row_in;

   logic [csm_pkg::SUM_W-1:0]   sum;
   logic                        sum_ovf;
   logic [csm_pkg::SUM_W-1:0]   acc_next;
   logic                        sat_next;
   logic [csm_pkg::TOTAL_W-1:0] row_limit;
   logic [csm_pkg::TOTAL_W-1:0] row_plus;
   logic                        is_last;
   logic                        finish;

   always_comb begin
      sum      = acc_ff + product;
      sum_ovf  = (acc_ff[csm_pkg::SUM_W-1] == product[csm_pkg::SUM_W-1]) &&
                 (sum[csm_pkg::SUM_W-1] != acc_ff[csm_pkg::SUM_W-1]);
      acc_next = sum_ovf ? (acc_ff[csm_pkg::SUM_W-1] ? SUM_MIN : SUM_MAX) : sum;
      sat_next = sat_ff | sum_ovf;

      // Zero or anything past the counter range wraps at the full 16 bits.
      row_limit = ((row_total == '0) || (row_total > ROW_LIMIT_MAX)) ? ROW_LIMIT_MAX
                                                                   : row_total;
      row_plus  = {1'b0, row_ff} + {{(csm_pkg::TOTAL_W-1){1'b0}}, 1'b1};
      is_last   = (row_plus == row_limit);

      finish = ctrl.valid && (!ctrl.mac || ctrl.row_end);

      acc_in        = acc_ff;
      sat_in        = sat_ff;
      row_in        = row_ff;
      valid_in      = valid_ff;
      row_number_in = row_number_ff;
      row_sum_in    = row_sum_ff;
      overflow_in   = overflow_ff;
      last_row_in   = last_row_ff;

      if (advance) begin
         valid_in = finish;
         if (ctrl.valid) begin
            if (ctrl.mac) begin
               acc_in = acc_next;
               sat_in = sat_next;
            end
            if (finish) begin
               row_number_in = row_ff;
               row_sum_in    = ctrl.mac ? acc_next : '0;
               overflow_in   = ctrl.mac ? sat_next : 1'b0;
               last_row_in   = is_last;
               row_in        = is_last ? '0 : row_plus[csm_pkg::ROW_W-1:0];
               acc_in        = '0;
               sat_in        = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_number_ff <= row_number_in;
      row_sum_ff    <= row_sum_in;
      overflow_ff   <= overflow_in;
      last_row_ff   <= last_row_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_row_number = row_number_ff;
   assign rsp_row_sum    = row_sum_ff;
   assign rsp_overflow   = overflow_ff;
   assign rsp_last_row   = last_row_ff;

endmodule

`default_nettype wire

// ===== rtl/core/csr_sparse_matvec_core.sv =====
// Top level of the compressed-row sparse matrix times dense vector core.
//
// Requests arrive on the req_ stream. A load request (kind 0) writes a Q8.24
// vector element into the local store. A nonzero request (kind 1) gathers the
// element at its column, multiplies it with the Q8.24 value and adds the
// Q16.48 product to a saturating accumulator; with tlast set it closes the row.
// An empty-row request (kind 2) closes the row with a zero sum.
// Each closed row leaves one result on the rsp_ stream: row number and sum in
// tdata, the saturation flag in tuser, the final-row flag in tlast.
// Throughput is one request per cycle while no result is stalled, set by the
// accumulator loop; the store read and the multiply are registered ahead of
// it. A result is registered in the row accumulator once the request closing
// its row has passed the s1 and s2 registers. When the receiver holds
// rsp_tready low with a result waiting, the whole pipeline holds and req_tready
// goes low until the result is taken. Reset clears the pipeline, the
// accumulator, the row counter and sets row_total to 1; the vector store keeps
// its contents and must be loaded before it is read. The user must write
// row_total through the csr_ port only while idle; the core does not check it.
`default_nettype none

module csr_sparse_matvec_core #(
   parameter int VECTOR_DEPTH = csm_pkg::VECTOR_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // request stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // column[9:0], value[41:10], zero fill
   input  wire  [1:0]  req_tuser,   // kind[1:0]
   input  wire         req_tlast,   // row_end
   // result stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [79:0] rsp_tdata,   // row_number[15:0], row_sum[79:16]
   output logic        rsp_tuser,   // overflow
   output logic        rsp_tlast,   // last_row
   // register port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = $clog2(VECTOR_DEPTH);
   localparam logic CSR_IDX_ROW_TOTAL = 1'b0;

   logic [csm_pkg::TOTAL_W-1:0] row_total_ff, row_total_in;

   csm_pkg::stage_ctrl_type     s1_ctrl_ff, s1_ctrl_in;
   logic [csm_pkg::VALUE_W-1:0] s1_value_ff;
   logic                        s1_range_ff;
   csm_pkg::stage_ctrl_type     s2_ctrl_ff, s2_ctrl_in;
   logic [csm_pkg::SUM_W-1:0]   s2_prod_ff;

   logic                        advance;
   logic                        accept;
   logic                        is_load, is_mac, is_empty;
   logic [csm_pkg::COLUMN_W-1:0] req_column;
   logic [csm_pkg::VALUE_W-1:0] req_value;
   logic [csm_pkg::TOTAL_W-1:0] column_wide;
   logic                        in_range;
   logic [ADDR_W-1:0]           store_addr;
   logic [csm_pkg::VALUE_W-1:0] store_rd_data;
   logic [csm_pkg::VALUE_W-1:0] gathered;
   logic [csm_pkg::SUM_W-1:0]   product;
   logic                        csr_write;

   logic                        res_valid;
   logic [csm_pkg::ROW_W-1:0]   res_row_number;
   logic [csm_pkg::SUM_W-1:0]   res_row_sum;
   logic                        res_overflow;
   logic                        res_last_row;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      row_total_in = row_total_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_ROW_TOTAL)) begin
         row_total_in = csr_pwdata[csm_pkg::TOTAL_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_ROW_TOTAL) begin
         csr_prdata = {{(32-csm_pkg::TOTAL_W){1'b0}}, row_total_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_total_ff <= {{(csm_pkg::TOTAL_W-1){1'b0}}, 1'b1};
      end else begin
         row_total_ff <= row_total_in;
      end
   end

   // hold every stage while a result waits
   assign advance    = !res_valid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   assign req_column  = req_tdata[csm_pkg::COLUMN_W-1:0];
   assign req_value   = req_tdata[csm_pkg::COLUMN_W +: csm_pkg::VALUE_W];
   assign column_wide = {{(csm_pkg::TOTAL_W-csm_pkg::COLUMN_W){1'b0}}, req_column};
   assign in_range    = 32'(req_column) < VECTOR_DEPTH;
   assign store_addr  = column_wide[ADDR_W-1:0];

   always_comb begin
      is_load  = 1'b0;
      is_mac   = 1'b0;
      is_empty = 1'b0;
      unique case (csm_pkg::kind_type'(req_tuser))
         csm_pkg::KIND_LOAD: begin
            is_load = 1'b1;
         end
         csm_pkg::KIND_NONZERO: begin
            is_mac = 1'b1;
         end
         csm_pkg::KIND_EMPTY: begin
            is_empty = 1'b1;
         end
         default: begin
            // unused kind: drop
         end
      endcase
   end

   csm_vec_store #(
      .DEPTH  (VECTOR_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && is_load && in_range),
      .wr_addr (store_addr),
      .wr_data (req_value),
      .rd_en   (advance),
      .rd_addr (store_addr),
      .rd_data (store_rd_data)
   );

   // stage 1: gather and multiply
   always_comb begin
      s1_ctrl_in.valid   = accept && (is_mac || is_empty);
      s1_ctrl_in.mac     = is_mac;
      s1_ctrl_in.row_end = req_tlast;

      gathered = s1_range_ff ? store_rd_data : '0;
      product  = $signed(s1_value_ff) * $signed(gathered);

      s2_ctrl_in = s1_ctrl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
      end else if (advance) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s2_ctrl_ff <= s2_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_value_ff <= req_value;
         s1_range_ff <= in_range;
         s2_prod_ff  <= product;
      end
   end

   // stage 2: accumulate, close rows, register the result
   csm_row_acc u_acc (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .ctrl           (s2_ctrl_ff),
      .product        (s2_prod_ff),
      .row_total      (row_total_ff),
      .rsp_valid      (res_valid),
      .rsp_row_number (res_row_number),
      .rsp_row_sum    (res_row_sum),
      .rsp_overflow   (res_overflow),
      .rsp_last_row   (res_last_row)
   );

   assign rsp_tvalid = res_valid;
   assign rsp_tdata  = {res_row_sum, res_row_number};
   assign rsp_tuser  = res_overflow;
   assign rsp_tlast  = res_last_row;

endmodule

`default_nettype wire

// ===== rtl/core/csm_checker.sv =====
// Port-level checks of the sparse matrix-vector core, bound to the top level.
`default_nettype none
`include "csr_sparse_matvec_core_defines.svh"

module csm_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [79:0] rsp_tdata,
   input wire        rsp_tuser,
   input wire        rsp_tlast
);

   // a stalled result holds its payload
   `CSM_ASSERT_NEXT(a_rsp_hold, clock, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), reset)

   // a waiting result stops the request side
   `CSM_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

   // with no result pending the core takes requests
   `CSM_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // reset empties the result register
   `CSM_ASSERT_ALWAYS_NEXT(a_reset_clears, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind csr_sparse_matvec_core csm_checker u_csm_checker (.*);

`default_nettype wire
